/* sv/alru_pkg.sv */
// shared constants and controller/datapath signal groups for the aging frame selector
package alru_pkg;

	localparam int FRAME_COUNT_DEF = 32;
	localparam int AGE_WIDTH_DEF   = 32;
	localparam int FRAME_W         = 5;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic miss;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

/* sv/alru_stream_if.sv */
// valid/ready channels for frame accesses and frame results
interface alru_req_if;
	logic                            valid;
	logic                            ready;
	logic                            is_miss;
	logic [alru_pkg::FRAME_W-1:0]    frame_in;
	logic                            update_age;

	modport source (output valid, output is_miss, output frame_in, output update_age,
		input ready);
	modport sink (input valid, input is_miss, input frame_in, input update_age,
		output ready);
endinterface

interface alru_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [alru_pkg::FRAME_W-1:0]    frame_out;
	logic                            was_victim;

	modport source (output valid, output frame_out, output was_victim, input ready);
	modport sink (input valid, input frame_out, input was_victim, output ready);
endinterface

/* sv/aging_lru_frame_replacement_top.sv */
// top level of the aging frame selector
// a hit goes from accept straight to the apply state, a miss first runs
// the victim scan, which reads one counter a cycle; the result register is loaded
// in the apply state once it is free, and only then is the next access taken
// a new access is taken while the previous result waits in the result register
// reset clears all aging counters and the control state at once
module aging_lru_frame_replacement_top #(
	parameter int FRAME_COUNT = alru_pkg::FRAME_COUNT_DEF,
	parameter int AGE_WIDTH   = alru_pkg::AGE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	alru_req_if.sink  req,
	alru_rsp_if.source rsp
);
	import alru_pkg::*;

	cmd_t    cmd;
	status_t sts;

	alru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_is_miss (req.is_miss),
		.in_ready   (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	alru_datapath #(
		.FRAME_COUNT (FRAME_COUNT),
		.AGE_WIDTH   (AGE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.is_miss    (req.is_miss),
		.frame_in   (req.frame_in),
		.update_age (req.update_age),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.frame_out  (rsp.frame_out),
		.was_victim (rsp.was_victim)
	);

endmodule

/* sv/alru_datapath.sv */
// aging counters, victim scan registers and result register
module alru_datapath #(
	parameter int FRAME_COUNT = alru_pkg::FRAME_COUNT_DEF,
	parameter int AGE_WIDTH   = alru_pkg::AGE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  alru_pkg::cmd_t               cmd,
	output alru_pkg::status_t            sts,
	input  logic                         is_miss,
	input  logic [alru_pkg::FRAME_W-1:0] frame_in,
	input  logic                         update_age,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [alru_pkg::FRAME_W-1:0] frame_out,
	output logic                         was_victim
);
	import alru_pkg::*;

	localparam int IDX_W = $clog2(FRAME_COUNT);
	localparam int UW    = (IDX_W > FRAME_W) ? IDX_W : FRAME_W;
	localparam logic [IDX_W-1:0]     LAST = IDX_W'(FRAME_COUNT - 1);
	localparam logic [AGE_WIDTH-1:0] GAIN = AGE_WIDTH'(1) << (AGE_WIDTH - 2);

	logic [AGE_WIDTH-1:0] age_q [FRAME_COUNT];
	logic [AGE_WIDTH-1:0] best_val_q;
	logic [IDX_W-1:0]     scan_idx_q;
	logic [UW-1:0]        used_q;
	logic                 miss_q;
	logic                 upd_q;
	logic                 out_valid_q;
	logic [FRAME_W-1:0]   frame_out_q;
	logic                 was_victim_q;
	logic [AGE_WIDTH-1:0] scan_val;
	logic                 better;

	function automatic logic [AGE_WIDTH-1:0] sat_gain(input logic [AGE_WIDTH-1:0] c);
		logic [AGE_WIDTH:0] sum;
		sum = {1'b0, c} + {1'b0, GAIN};
		return sum[AGE_WIDTH] ? {AGE_WIDTH{1'b1}} : sum[AGE_WIDTH-1:0];
	endfunction

	assign scan_val = age_q[scan_idx_q];
	assign better   = scan_val < best_val_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			miss_q     <= is_miss;
			upd_q      <= update_age;
			used_q     <= is_miss ? '0 : UW'(frame_in);
			best_val_q <= age_q[0];
			scan_idx_q <= IDX_W'(1);
		end else if (cmd.scan_step) begin
			if (better) begin
				best_val_q <= scan_val;
				used_q     <= UW'(scan_idx_q);
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// on an aging update the used frame gains, all others halve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_COUNT; i++) age_q[i] <= '0;
		end else if (cmd.apply && upd_q) begin
			for (int i = 0; i < FRAME_COUNT; i++) begin
				if (used_q == UW'(i)) age_q[i] <= sat_gain(age_q[i]);
				else age_q[i] <= age_q[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			frame_out_q  <= used_q[FRAME_W-1:0];
			was_victim_q <= miss_q;
		end
	end

	assign sts.miss      = miss_q;
	assign sts.scan_last = (scan_idx_q == LAST);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign frame_out  = frame_out_q;
	assign was_victim = was_victim_q;

	a_apply_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid_q)
		else $error("result register not loaded after apply");

	a_scan_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step && !sts.scan_last |=> scan_idx_q == IDX_W'($past(scan_idx_q) + 1'b1))
		else $error("scan index did not advance");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(frame_out_q) &&
		$stable(was_victim_q))
		else $error("waiting result changed before its transfer");

endmodule

/* sv/alru_ctrl.sv */
// sequencer for accept, victim scan and counter update
module alru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_is_miss,
	output logic              in_ready,
	input  alru_pkg::status_t sts,
	output alru_pkg::cmd_t    cmd
);
	import alru_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.apply     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_is_miss ? ST_SCAN : ST_APPLY;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (sts.out_free) begin
					cmd.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_miss_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && in_is_miss |=> state_q == ST_SCAN)
		else $error("miss did not start a scan");

	a_apply_returns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> state_q == ST_IDLE)
		else $error("no return to idle after apply");

	a_apply_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY && !sts.out_free |=> state_q == ST_APPLY && !$past(cmd.apply))
		else $error("apply while result register full");

endmodule

/* tb/alru_access_checker.sv */
`timescale 1ns / 100ps
// checker for the aging frame selector: predicts every access and compares each frame result
module alru_access_checker #(
	parameter int FRAME_COUNT = alru_pkg::FRAME_COUNT_DEF,
	parameter int AGE_WIDTH   = alru_pkg::AGE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic                         is_miss,
	input  logic [alru_pkg::FRAME_W-1:0] frame_in,
	input  logic                         update_age,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic [alru_pkg::FRAME_W-1:0] frame_out,
	input  logic                         was_victim,
	output int                           fail_count,
	output int                           outstanding,
	output int                           compared,
	output int                           clamped
);
	import alru_pkg::*;

	typedef struct {
		logic [FRAME_W-1:0] frame;
		logic               victim;
	} frame_result_t;

	localparam logic [AGE_WIDTH-1:0] AGE_GAIN = {2'b01, {(AGE_WIDTH-2){1'b0}}};

	logic [AGE_WIDTH-1:0] ages [FRAME_COUNT];
	frame_result_t        expected_frames [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
		compared    = 0;
		clamped     = 0;
	end

	task automatic predict_access(input logic miss, input logic [FRAME_W-1:0] fin,
		input logic upd);
		int            used;
		logic [AGE_WIDTH:0] sum;
		frame_result_t r;
		used = fin;
		if (miss) begin
			used = 0;
			for (int i = 1; i < FRAME_COUNT; i++)
				if (ages[i] < ages[used])
					used = i;
		end
		if (upd) begin
			for (int i = 0; i < FRAME_COUNT; i++) begin
				if (i == used) begin
					sum = {1'b0, ages[i]} + {1'b0, AGE_GAIN};
					if (sum[AGE_WIDTH]) begin
						ages[i] = '1;
						clamped++;
					end else begin
						ages[i] = sum[AGE_WIDTH-1:0];
					end
				end else begin
					ages[i] = ages[i] >> 1;
				end
			end
		end
		r.frame  = used[FRAME_W-1:0];
		r.victim = miss;
		expected_frames.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			foreach (ages[i])
				ages[i] = '0;
			expected_frames.delete();
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_frames.size() == 0) begin
					$error("result with no access waiting: frame_out=%0d was_victim=%0d",
						frame_out, was_victim);
					fail_count++;
				end else begin
					want = expected_frames.pop_front();
					compared++;
					if (frame_out !== want.frame) begin
						$error("frame_out mismatch: expected %0d, actual %0d",
							want.frame, frame_out);
						fail_count++;
					end
					if (was_victim !== want.victim) begin
						$error("was_victim mismatch: expected %0d, actual %0d",
							want.victim, was_victim);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				predict_access(is_miss, frame_in, update_age);
			outstanding = expected_frames.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench top for the aging frame selector: clock, reset, access stimulus and verdict
module tb;
	import alru_pkg::*;

	localparam int N_RANDOM   = 900;
	localparam int HOLD_LEN   = 300;
	localparam int CYCLE_CAP  = 200000;
	localparam int CALM_TAIL  = 120;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_rx;
	int   fail_count;
	int   outstanding;
	int   compared;
	int   clamped;
	int   hits_sent;
	int   misses_sent;
	int   ages_sent;
	int   cycles;

	alru_req_if req_if();
	alru_rsp_if rsp_if();

	aging_lru_frame_replacement_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	alru_access_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.is_miss     (req_if.is_miss),
		.frame_in    (req_if.frame_in),
		.update_age  (req_if.update_age),
		.rsp_valid   (rsp_if.valid),
		.rsp_ready   (rsp_if.ready),
		.frame_out   (rsp_if.frame_out),
		.was_victim  (rsp_if.was_victim),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.compared    (compared),
		.clamped     (clamped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// result side: random back-pressure bursts, plus one long hold-off on request
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				rsp_if.ready <= 1'b0;
				for (int n = 0; n < HOLD_LEN; n++)
					@(posedge clk);
				hold_rx = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_access(input logic miss, input logic [FRAME_W-1:0] fr,
		input logic upd);
		req_if.valid      <= 1'b1;
		req_if.is_miss    <= miss;
		req_if.frame_in   <= fr;
		req_if.update_age <= upd;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (miss)
			misses_sent++;
		else
			hits_sent++;
		if (upd)
			ages_sent++;
	endtask

	initial begin
		logic [FRAME_W-1:0] hot [4];
		logic [FRAME_W-1:0] fr;
		logic               miss;
		logic               upd;
		int                 run_left;
		logic [FRAME_W-1:0] run_frame;

		hits_sent   = 0;
		misses_sent = 0;
		ages_sent   = 0;
		calm        = 1'b1;
		hold_rx     = 1'b0;
		run_left    = 0;
		run_frame   = '0;
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.is_miss    <= 1'b0;
		req_if.frame_in   <= '0;
		req_if.update_age <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all counters equal: lowest index wins, then the next one up
		send_access(1'b1, 5'd31, 1'b0);
		send_access(1'b1, 5'd17, 1'b1);
		send_access(1'b1, 5'd0, 1'b1);
		// repeated gain on one frame runs into saturation
		repeat (6) send_access(1'b0, 5'd31, 1'b1);
		send_access(1'b0, 5'd0, 1'b0);
		send_access(1'b0, 5'd31, 1'b0);
		for (int b = 0; b < FRAME_W; b++)
			send_access(1'b0, FRAME_W'(1 << b), 1'b1);
		send_access(1'b0, 5'd30, 1'b1);
		send_access(1'b1, 5'd0, 1'b0);
		send_access(1'b1, 5'd31, 1'b1);
		send_access(1'b1, 5'd1, 1'b1);
		send_access(1'b0, 5'd15, 1'b0);

		// drain fully before the random part
		req_if.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);

		foreach (hot[i])
			hot[i] = FRAME_W'($urandom_range(0, 31));
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 60 == 0) begin
				calm = (k >= N_RANDOM - CALM_TAIL) || ($urandom_range(0, 2) == 0);
				foreach (hot[i])
					hot[i] = FRAME_W'($urandom_range(0, 31));
			end
			if (k == 300)
				hold_rx = 1'b1;
			if (run_left == 0 && $urandom_range(0, 19) == 0) begin
				run_left  = $urandom_range(3, 7);
				run_frame = FRAME_W'($urandom_range(0, 31));
			end
			if (run_left > 0) begin
				miss = 1'b0;
				fr   = run_frame;
				upd  = 1'b1;
				run_left--;
			end else begin
				miss = ($urandom_range(0, 9) < 3);
				upd  = ($urandom_range(0, 9) < 7);
				if ($urandom_range(0, 9) < 4)
					fr = hot[$urandom_range(0, 3)];
				else
					fr = FRAME_W'($urandom_range(0, 31));
			end
			send_access(miss, fr, upd);
			if (!calm && $urandom_range(0, 3) == 0) begin
				req_if.valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end

		req_if.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (alru_pkg::FRAME_COUNT_DEF + 8) @(posedge clk);

		$display("%0d accesses sent: %0d hits, %0d misses, %0d with aging",
			hits_sent + misses_sent, hits_sent, misses_sent, ages_sent);
		$display("%0d results compared, %0d saturating gains predicted", compared, clamped);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/alru_pkg.sv
sv/alru_stream_if.sv
sv/alru_datapath.sv
sv/alru_ctrl.sv
sv/aging_lru_frame_replacement_top.sv
tb/alru_access_checker.sv
tb/tb.sv
